@@ hw/rtl/owrs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owrs_pkg
// Types and constants shared by the ROM search engine modules.
// ----------------------------------------------------------------------------
package owrs_pkg;

    typedef enum logic [1:0] {
        OP_FIRST = 2'd0,
        OP_NEXT  = 2'd1,
        OP_BIT   = 2'd2,
        OP_NOP   = 2'd3
    } owrs_op_t;

    localparam logic [6:0] FAMILY_LIMIT = 7'd9;
    localparam logic [7:0] CRC_POLY     = 8'h8C;

    typedef struct packed {
        owrs_op_t opcode;
        logic     presence;
        logic     id_bit;
        logic     cmp_bit;
    } owrs_req_t;

    typedef struct packed {
        logic [3:0]  family_discrepancy;
        logic [63:0] rom_code;
        logic        last_device;
        logic        found;
        logic        done_res;
        logic        write_bit;
        logic        write_valid;
    } owrs_res_t;

endpackage

@@ hw/rtl/owrs_in_reg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owrs_in_reg
// Input register stage that holds one request until the engine takes it.
// ----------------------------------------------------------------------------
module owrs_in_reg
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_user,
    input  logic [7:0]          s_data,
    input  logic                take,
    output logic                valid,
    output owrs_pkg::owrs_req_t req
);
    import owrs_pkg::*;

    logic      valid_reg;
    owrs_req_t req_reg;

    assign s_ready = !valid_reg || take;
    assign valid   = valid_reg;
    assign req     = req_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_ready)
        begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_ready && s_valid)
        begin
            req_reg.opcode   <= owrs_op_t'(s_user);
            req_reg.presence <= s_data[0];
            req_reg.id_bit   <= s_data[1];
            req_reg.cmp_bit  <= s_data[2];
        end
    end

endmodule

@@ hw/rtl/owrs_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owrs_engine
// Search state, direction choice and ROM register update per request; CRC8 update per completed byte.
// ----------------------------------------------------------------------------
module owrs_engine
#(
    parameter int ROM_BYTES = 8
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  owrs_pkg::owrs_req_t req,
    output owrs_pkg::owrs_res_t res
);
    import owrs_pkg::*;

    localparam int         ROM_W    = ROM_BYTES * 8;
    localparam int         IDX_W    = $clog2(ROM_W);
    localparam logic [6:0] LAST_POS = 7'(ROM_W);

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    logic [ROM_W-1:0] rom_reg,       rom_next;
    logic [6:0]       last_disc_reg, last_disc_next;
    logic             last_dev_reg,  last_dev_next;
    logic [3:0]       fam_disc_reg,  fam_disc_next;
    logic [6:0]       pos_reg,       pos_next;
    logic [6:0]       last_zero_reg, last_zero_next;
    logic [7:0]       crc_reg,       crc_next;
    logic             active_reg,    active_next;

    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] byte_base;
    logic             dir;
    logic [7:0]       byte_val;

    assign idx       = IDX_W'(pos_reg - 7'd1);
    assign byte_base = idx & ~IDX_W'(7);

    always_comb
    begin
        rom_next       = rom_reg;
        last_disc_next = last_disc_reg;
        last_dev_next  = last_dev_reg;
        fam_disc_next  = fam_disc_reg;
        pos_next       = pos_reg;
        last_zero_next = last_zero_reg;
        crc_next       = crc_reg;
        active_next    = active_reg;
        dir            = 1'b0;
        byte_val       = 8'd0;
        res            = '0;

        case (req.opcode)
            OP_FIRST, OP_NEXT:
            begin
                if (req.opcode == OP_FIRST)
                begin
                    last_disc_next = 7'd0;
                    last_dev_next  = 1'b0;
                    fam_disc_next  = 4'd0;
                end
                pos_next       = 7'd1;
                last_zero_next = 7'd0;
                crc_next       = 8'd0;
                active_next    = 1'b0;
                if ((req.opcode == OP_NEXT && last_dev_reg) || !req.presence)
                begin
                    last_disc_next = 7'd0;
                    last_dev_next  = 1'b0;
                    fam_disc_next  = 4'd0;
                    res.done_res   = 1'b1;
                end
                else
                begin
                    active_next = 1'b1;
                end
            end
            OP_BIT:
            begin
                if (active_reg)
                begin
                    if (req.id_bit && req.cmp_bit)
                    begin
                        last_disc_next = 7'd0;
                        last_dev_next  = 1'b0;
                        fam_disc_next  = 4'd0;
                        active_next    = 1'b0;
                        res.done_res   = 1'b1;
                    end
                    else
                    begin
                        if (req.id_bit != req.cmp_bit)
                        begin
                            dir = req.id_bit;
                        end
                        else
                        begin
                            if (pos_reg < last_disc_reg)
                            begin
                                dir = rom_reg[idx];
                            end
                            else
                            begin
                                dir = (pos_reg == last_disc_reg);
                            end
                            if (!dir)
                            begin
                                last_zero_next = pos_reg;
                                if (pos_reg < FAMILY_LIMIT)
                                begin
                                    fam_disc_next = pos_reg[3:0];
                                end
                            end
                        end
                        rom_next[idx]   = dir;
                        res.write_valid = 1'b1;
                        res.write_bit   = dir;
                        if (pos_reg[2:0] == 3'd0)
                        begin
                            byte_val = rom_next[byte_base +: 8];
                            crc_next = crc8_byte(crc_reg, byte_val);
                        end
                        pos_next = pos_reg + 7'd1;
                        if (pos_reg == LAST_POS)
                        begin
                            active_next  = 1'b0;
                            res.done_res = 1'b1;
                            if (crc_next == 8'd0 && rom_next[7:0] != 8'd0)
                            begin
                                last_disc_next  = last_zero_next;
                                last_dev_next   = last_dev_reg || (last_zero_next == 7'd0);
                                res.found       = 1'b1;
                                res.last_device = last_dev_next;
                            end
                            else
                            begin
                                last_disc_next = 7'd0;
                                last_dev_next  = 1'b0;
                                fam_disc_next  = 4'd0;
                            end
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase

        res.rom_code           = 64'(rom_next);
        res.family_discrepancy = fam_disc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_reg       <= '0;
            last_disc_reg <= 7'd0;
            last_dev_reg  <= 1'b0;
            fam_disc_reg  <= 4'd0;
            pos_reg       <= 7'd1;
            last_zero_reg <= 7'd0;
            crc_reg       <= 8'd0;
            active_reg    <= 1'b0;
        end
        else if (fire)
        begin
            rom_reg       <= rom_next;
            last_disc_reg <= last_disc_next;
            last_dev_reg  <= last_dev_next;
            fam_disc_reg  <= fam_disc_next;
            pos_reg       <= pos_next;
            last_zero_reg <= last_zero_next;
            crc_reg       <= crc_next;
            active_reg    <= active_next;
        end
    end

endmodule

@@ hw/rtl/owrs_out_reg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owrs_out_reg
// Result register that holds one result until the sink takes it.
// ----------------------------------------------------------------------------
module owrs_out_reg
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  owrs_pkg::owrs_res_t res,
    output logic                can_load,
    output logic                m_valid,
    input  logic                m_ready,
    output owrs_pkg::owrs_res_t m_res
);
    import owrs_pkg::*;

    logic      valid_reg;
    owrs_res_t res_reg;

    assign can_load = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_res    = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (can_load)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

endmodule

@@ hw/rtl/onewire_rom_search.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// onewire_rom_search
// 1-Wire ROM search engine: one direction bit and search state update per
// bit request; first and next requests reset the pass position.
// ----------------------------------------------------------------------------
//  Channel  Dir  tdata (low bit up)                              tuser   tlast
//  s_axis   in   presence, id_bit, cmp_bit, pad to 8 bits        opcode  -
//  m_axis   out  write_valid, write_bit, done_res, found,        -       last_device
//                rom_code[63:0], family_discrepancy[3:0]
//
// A request is taken every cycle while the result register can load; the
// result is loaded into the result register when the request is taken.
// Reset clears the search state and both stages at once.
// A stalled result holds while the input register still takes one request.
// ----------------------------------------------------------------------------
module onewire_rom_search
#(
    parameter int ROM_BYTES = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // presence, id_bit, cmp_bit, zero pad
    input  logic [1:0]  s_axis_tuser,   // opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // write_valid, write_bit, done_res, found,
                                        // rom_code, family_discrepancy
    output logic        m_axis_tlast    // last_device
);
    import owrs_pkg::*;

    logic      in_valid;
    owrs_req_t req;
    owrs_res_t res;
    owrs_res_t out_res;
    logic      can_load;
    logic      fire;

    assign fire = in_valid && can_load;

    owrs_in_reg u_in
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .s_user  (s_axis_tuser),
        .s_data  (s_axis_tdata),
        .take    (fire),
        .valid   (in_valid),
        .req     (req)
    );

    owrs_engine #(.ROM_BYTES(ROM_BYTES)) u_engine
    (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .req   (req),
        .res   (res)
    );

    owrs_out_reg u_out
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (fire),
        .res      (res),
        .can_load (can_load),
        .m_valid  (m_axis_tvalid),
        .m_ready  (m_axis_tready),
        .m_res    (out_res)
    );

    assign m_axis_tdata = {out_res.family_discrepancy, out_res.rom_code, out_res.found,
                           out_res.done_res, out_res.write_bit, out_res.write_valid};
    assign m_axis_tlast = out_res.last_device;

endmodule

@@ hw/rtl/owrs_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owrs_checker
// Port-level checks of the ROM search engine results.
// ----------------------------------------------------------------------------
module owrs_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [71:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast))
        else $error("stalled result changed");

    a_found_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[3] |-> m_axis_tdata[2] && m_axis_tdata[0])
        else $error("found without a finished pass");

    a_last_found: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[3])
        else $error("last device without found");

    a_bit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[1] |-> m_axis_tdata[0])
        else $error("direction bit without write request");

    a_family: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[3] |-> m_axis_tdata[11:4] != 8'd0)
        else $error("found with zero family byte");

endmodule

bind onewire_rom_search owrs_checker u_owrs_checker (.*);
